FILE: rtl/slist_pkg.sv
// ============================================================================
// Sorted list package
// Shared constants, operation codes and the structs that pass between the
// cells, the output buffer and the top level.
// ============================================================================
package slist_pkg;

    localparam int SLOTS   = 32;
    localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int DATA_W  = 32;
    localparam int INDEX_W = 5;
    localparam int OUT_W   = 6;
    localparam int WIDE_W  = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_CLEAR  = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_FULL   = 2'd1,
        ST_NOSLOT = 2'd2
    } status_t;

    typedef struct packed {
        logic               ins_en;
        logic               rem_en;
        logic [DATA_W-1:0]  value;
        logic [IDX_W-1:0]   rem_idx;
        logic [CNT_W-1:0]   held;
    } slist_op_t;

    typedef struct packed {
        status_t            status;
        logic [OUT_W-1:0]   fill_count;
        logic               is_empty;
        logic               is_full;
        logic [OUT_W-1:0]   compares;
        logic [OUT_W-1:0]   moves;
    } slist_res_t;

endpackage

FILE: rtl/slist_cell.sv
// ============================================================================
// Sorted list cell
// Holds one list entry. On an insert it compares its entry with the new
// value and takes either the new value or its lower neighbor's entry; on a
// remove it takes its upper neighbor's entry.
// ============================================================================
module slist_cell (
    input  logic                         clk,
    input  logic [slist_pkg::IDX_W-1:0]  pos,
    input  slist_pkg::slist_op_t         op,
    input  logic [slist_pkg::DATA_W-1:0] entry_lower,
    input  logic                         gt_lower,
    input  logic [slist_pkg::DATA_W-1:0] entry_upper,
    output logic [slist_pkg::DATA_W-1:0] entry,
    output logic                         gt,
    output logic                         first_gt
);
    import slist_pkg::*;

    logic [DATA_W-1:0] entry_reg;
    logic [DATA_W-1:0] entry_next;
    logic [CNT_W-1:0]  pos_cnt;
    logic              occupied;
    logic              take_insert;
    logic              take_upper;

    assign pos_cnt  = CNT_W'(pos);
    assign occupied = pos_cnt < op.held;
    assign gt       = occupied && ($signed(entry_reg) > $signed(op.value));
    assign first_gt = gt && !gt_lower;

    assign take_insert = op.ins_en && (gt || (pos_cnt == op.held));
    assign take_upper  = op.rem_en && (pos >= op.rem_idx) && ((pos_cnt + 1'b1) < op.held);

    always_comb
    begin
        priority if (take_insert)
        begin
            entry_next = gt_lower ? entry_lower : op.value;
        end
        else if (take_upper)
        begin
            entry_next = entry_upper;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

FILE: rtl/slist_out_buf.sv
// ============================================================================
// Sorted list output buffer
// Output register with one skid entry, so that a new item can be taken
// while a finished result still waits on the output.
// ============================================================================
module slist_out_buf (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  res_valid,
    input  slist_pkg::slist_res_t res,
    output logic                  busy,
    output logic                  out_valid,
    input  logic                  out_stall,
    output slist_pkg::slist_res_t out_res
);
    import slist_pkg::*;

    logic       out_valid_reg;
    logic       skid_valid_reg;
    slist_res_t out_res_reg;
    slist_res_t skid_res_reg;
    logic       out_take;

    assign out_take = out_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            priority if (skid_valid_reg)
            begin
                if (out_take)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (res_valid)
            begin
                if (out_valid_reg && !out_take)
                begin
                    skid_valid_reg <= 1'b1;
                end
                else
                begin
                    out_valid_reg <= 1'b1;
                end
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        priority if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_res_reg <= skid_res_reg;
            end
        end
        else if (res_valid)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_res_reg <= res;
            end
            else
            begin
                out_res_reg <= res;
            end
        end
    end

    assign busy      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule

FILE: rtl/sorted_list_insert_remove.sv
// ============================================================================
// Sorted list with insert, remove and clear
// Keeps an ascending list of signed values in a row of cells and reports
// status, fill level and the compare and move counts of each operation.
// ============================================================================
//
//   Channel  Signals                                   Direction
//   -------  ----------------------------------------  ---------
//   in       in_valid, in_stall, action, value, index   into block
//   out      out_valid, out_stall, status, fill_count,  out of block
//            is_empty, is_full, compares, moves
//
// All cells compare and shift in parallel, and the result is registered at the
// input transfer, in the output register or, while that waits, the skid entry.
// One operation is taken per cycle while the output keeps up.
// A skid entry holds a second result when the output is stalled; the input
// stalls only while that entry is occupied.
// Reset clears the fill count and the output handshake; entries need none.
//
module sorted_list_insert_remove (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   action,
    input  logic signed [31:0]           value,
    input  logic [4:0]                   index,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [1:0]                   status,
    output logic [5:0]                   fill_count,
    output logic                         is_empty,
    output logic                         is_full,
    output logic [5:0]                   compares,
    output logic [5:0]                   moves
);
    import slist_pkg::*;

    logic [CNT_W-1:0]  held_reg;
    logic [CNT_W-1:0]  held_next;
    logic              in_fire;
    logic              busy;
    logic [WIDE_W-1:0] idx_wide;
    logic [WIDE_W-1:0] held_wide;
    logic              ins_ok;
    logic              rem_ok;
    slist_op_t         op;
    slist_res_t        res;
    slist_res_t        out_res;

    logic [DATA_W-1:0] entry_w [SLOTS];
    logic [SLOTS-1:0]  gt_w;
    logic [SLOTS-1:0]  first_gt_w;
    logic [IDX_W-1:0]  found_pos;
    logic [CNT_W-1:0]  ins_pos;
    logic [CNT_W-1:0]  ins_cmp;
    logic [CNT_W-1:0]  rem_mov;

    assign in_stall = busy;
    assign in_fire  = in_valid && !busy;

    assign idx_wide  = WIDE_W'(index);
    assign held_wide = WIDE_W'(held_reg);

    assign ins_ok = in_fire && (action == ACT_INSERT) && (held_reg < CNT_W'(SLOTS));
    assign rem_ok = in_fire && (action == ACT_REMOVE) && (idx_wide < held_wide);

    assign op.ins_en  = ins_ok;
    assign op.rem_en  = rem_ok;
    assign op.value   = value;
    assign op.rem_idx = idx_wide[IDX_W-1:0];
    assign op.held    = held_reg;

    genvar g;
    generate
        for (g = 0; g < SLOTS; g++)
        begin : g_cell
            logic [DATA_W-1:0] lower_entry;
            logic              lower_gt;
            logic [DATA_W-1:0] upper_entry;

            if (g == 0)
            begin : g_first
                assign lower_entry = '0;
                assign lower_gt    = 1'b0;
            end
            else
            begin : g_mid_low
                assign lower_entry = entry_w[g-1];
                assign lower_gt    = gt_w[g-1];
            end

            if (g == SLOTS - 1)
            begin : g_last
                assign upper_entry = '0;
            end
            else
            begin : g_mid_high
                assign upper_entry = entry_w[g+1];
            end

            slist_cell u_cell (
                .clk         (clk),
                .pos         (IDX_W'(g)),
                .op          (op),
                .entry_lower (lower_entry),
                .gt_lower    (lower_gt),
                .entry_upper (upper_entry),
                .entry       (entry_w[g]),
                .gt          (gt_w[g]),
                .first_gt    (first_gt_w[g])
            );
        end
    endgenerate

    // The greater entries form one run at the top of the list, so the start
    // of that run is a one-hot flag and is encoded by an OR of indexes.
    always_comb
    begin
        found_pos = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            found_pos = found_pos | (first_gt_w[i] ? IDX_W'(i) : '0);
        end
    end

    assign ins_pos = (|first_gt_w) ? CNT_W'(found_pos) : held_reg;
    assign ins_cmp = held_reg - ins_pos;
    assign rem_mov = held_reg - 1'b1 - CNT_W'(op.rem_idx);

    always_comb
    begin
        held_next      = held_reg;
        res.status     = ST_DONE;
        res.compares   = '0;
        res.moves      = '0;
        unique case (action)
            ACT_INSERT:
            begin
                if (ins_ok)
                begin
                    held_next    = held_reg + 1'b1;
                    res.compares = OUT_W'(ins_cmp);
                    res.moves    = OUT_W'(ins_cmp);
                end
                else
                begin
                    res.status = ST_FULL;
                end
            end
            ACT_REMOVE:
            begin
                if (rem_ok)
                begin
                    held_next    = held_reg - 1'b1;
                    res.compares = OUT_W'(1);
                    res.moves    = OUT_W'(rem_mov);
                end
                else
                begin
                    res.status = ST_NOSLOT;
                end
            end
            ACT_CLEAR:
            begin
                held_next = '0;
            end
            default:
            begin
                held_next = held_reg;
            end
        endcase
        res.fill_count = OUT_W'(held_next);
        res.is_empty   = (held_next == '0);
        res.is_full    = (held_next == CNT_W'(SLOTS));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
        end
        else if (in_fire)
        begin
            held_reg <= held_next;
        end
    end

    slist_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (in_fire),
        .res       (res),
        .busy      (busy),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    assign status     = out_res.status;
    assign fill_count = out_res.fill_count;
    assign is_empty   = out_res.is_empty;
    assign is_full    = out_res.is_full;
    assign compares   = out_res.compares;
    assign moves      = out_res.moves;

`ifndef SYNTHESIS
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= CNT_W'(SLOTS))
        else $error("fill count exceeds the number of slots");

    a_one_run: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(first_gt_w))
        else $error("greater entries do not form a single run");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ins_ok |=> held_reg == $past(held_reg) + 1'b1)
        else $error("accepted insert did not grow the list");

    a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        rem_ok |=> held_reg == $past(held_reg) - 1'b1)
        else $error("accepted remove did not shrink the list");
`endif

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// Testbench for the sorted list with insert, remove and clear
// A driver and a monitor exercise the block with a directed opening and then
// long runs of insert-heavy, remove-heavy and mixed operations. Both channels
// idle and stall at random. Every result is checked field by field against a
// behavioral copy of the list that is kept in the testbench.
// ============================================================================
module tb;
    import slist_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int RANDOM_OPS = 1650;
    localparam int MAX_CYCLES = 200000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

    typedef struct {
        logic [1:0]         act;
        logic signed [31:0] val;
        logic [4:0]         idx;
        bit                 settle;
    } list_op_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         action = ACT_INSERT;
    logic signed [31:0] value = '0;
    logic [4:0]         index = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [1:0]         status;
    logic [5:0]         fill_count;
    logic               is_empty;
    logic               is_full;
    logic [5:0]         compares;
    logic [5:0]         moves;

    list_op_t           pending[$];
    slist_res_t         expected_q[$];
    logic signed [31:0] list_vals[SLOTS];
    int                 list_len = 0;
    int                 gen_len = 0;
    bit                 in_fire = 1'b0;
    bit                 out_fire = 1'b0;
    bit                 in_calm = 1'b0;
    bit                 out_calm = 1'b0;
    int                 in_hold = 0;
    int                 out_hold = 0;
    int                 cycles = 0;
    int                 mismatches = 0;
    int                 checked = 0;
    int                 rejects = 0;
    int                 noslots = 0;
    int                 peak_fill = 0;

    sorted_list_insert_remove dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .value      (value),
        .index      (index),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .fill_count (fill_count),
        .is_empty   (is_empty),
        .is_full    (is_full),
        .compares   (compares),
        .moves      (moves)
    );

    function automatic slist_res_t apply_list_op(logic [1:0] act, logic signed [31:0] val,
                                                 logic [4:0] idx);
        slist_res_t res;
        int         above;
        int         shifted;
        int         pos;
        res = '0;
        res.status = ST_DONE;
        above = 0;
        shifted = 0;
        case (act)
            ACT_INSERT:
            begin
                if (list_len >= SLOTS)
                begin
                    res.status = ST_FULL;
                end
                else
                begin
                    for (int i = 0; i < list_len; i++)
                    begin
                        if (list_vals[i] > val)
                            above++;
                    end
                    pos = list_len - above;
                    for (int i = list_len; i > pos; i--)
                        list_vals[i] = list_vals[i - 1];
                    list_vals[pos] = val;
                    shifted = above;
                    list_len++;
                end
            end
            ACT_REMOVE:
            begin
                if (int'(idx) >= list_len)
                begin
                    res.status = ST_NOSLOT;
                end
                else
                begin
                    for (int i = int'(idx); i + 1 < list_len; i++)
                        list_vals[i] = list_vals[i + 1];
                    shifted = list_len - 1 - int'(idx);
                    above = 1;
                    list_len--;
                end
            end
            ACT_CLEAR:
            begin
                list_len = 0;
            end
            default:
            begin
            end
        endcase
        res.fill_count = 6'(list_len);
        res.is_empty = (list_len == 0);
        res.is_full = (list_len == SLOTS);
        res.compares = 6'(above);
        res.moves = 6'(shifted);
        return res;
    endfunction

    function automatic int draw_wait(inout bit calm);
        if ($urandom_range(0, 39) == 0)
            calm = !calm;
        return calm ? 0 : int'($urandom_range(0, 7));
    endfunction

    task automatic add_op(logic [1:0] act, logic signed [31:0] val, logic [4:0] idx,
                          bit settle = 1'b0);
        list_op_t op;
        op.act = act;
        op.val = val;
        op.idx = idx;
        op.settle = settle;
        pending.push_back(op);
        case (act)
            ACT_INSERT:
            begin
                if (gen_len < SLOTS)
                    gen_len++;
            end
            ACT_REMOVE:
            begin
                if (int'(idx) < gen_len)
                    gen_len--;
            end
            ACT_CLEAR:
            begin
                gen_len = 0;
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > MAX_CYCLES)
        begin
            $display("Run stopped after %0d cycles with %0d results outstanding",
                     cycles, expected_q.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // Input transfers are predicted before results are checked on the same
    // edge; a result is registered, so it always trails its own transfer.
    always @(posedge clk)
    begin
        slist_res_t want;
        in_fire <= rst_n && in_valid && !in_stall;
        out_fire <= rst_n && out_valid && !out_stall;
        if (rst_n && in_valid && !in_stall)
        begin
            want = apply_list_op(action, value, index);
            if (want.status == ST_FULL)
                rejects++;
            if (want.status == ST_NOSLOT)
                noslots++;
            if (list_len > peak_fill)
                peak_fill = list_len;
            expected_q.push_back(want);
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual status %0d fill %0d",
                         $time, status, fill_count);
            end
            else
            begin
                want = expected_q.pop_front();
                checked++;
                check_field("status", int'(want.status), int'(status));
                check_field("fill_count", int'(want.fill_count), int'(fill_count));
                check_field("is_empty", int'(want.is_empty), int'(is_empty));
                check_field("is_full", int'(want.is_full), int'(is_full));
                check_field("compares", int'(want.compares), int'(compares));
                check_field("moves", int'(want.moves), int'(moves));
            end
        end
    end

    always @(negedge clk)
    begin
        list_op_t op;
        if (rst_n && !(in_valid && !in_fire))
        begin
            if (in_valid)
                in_hold = draw_wait(in_calm);
            if (in_hold > 0)
            begin
                in_hold--;
                in_valid <= 1'b0;
            end
            else if (pending.size() > 0 && !(pending[0].settle && expected_q.size() > 0))
            begin
                op = pending.pop_front();
                action <= op.act;
                value <= op.val;
                index <= op.idx;
                in_valid <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_fire)
                out_hold = draw_wait(out_calm);
            if (out_hold > 0)
            begin
                out_hold--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        int                 mode;
        int                 run_left;
        int                 ins_share;
        int                 pick;
        logic [1:0]         act;
        logic signed [31:0] val;
        logic [4:0]         idx;

        add_op(ACT_REMOVE, 0, 5'd0);
        add_op(ACT_UNUSED, 0, 5'd0);
        add_op(ACT_INSERT, VAL_MAX, 5'd0);
        add_op(ACT_INSERT, VAL_MIN, 5'd0);
        add_op(ACT_INSERT, 0, 5'd31);
        add_op(ACT_INSERT, -1, 5'd0);
        add_op(ACT_INSERT, 1, 5'd0);
        add_op(ACT_INSERT, 0, 5'd0);
        add_op(ACT_INSERT, VAL_MAX, 5'd0);
        add_op(ACT_INSERT, VAL_MIN, 5'd0);
        add_op(ACT_UNUSED, 32'sh5555_5555, 5'd21);
        add_op(ACT_REMOVE, 0, 5'd31);
        add_op(ACT_REMOVE, 0, 5'd8);
        add_op(ACT_REMOVE, 0, 5'd7);
        add_op(ACT_REMOVE, 0, 5'd0);
        add_op(ACT_REMOVE, 32'shAAAA_AAAA, 5'd3);
        add_op(ACT_CLEAR, -1, 5'd31);
        add_op(ACT_INSERT, -5, 5'd10, 1'b1);
        add_op(ACT_CLEAR, 0, 5'd0);
        add_op(ACT_CLEAR, 0, 5'd0);
        add_op(ACT_INSERT, 7, 5'd0);

        // Each run picks filling, draining or mixed traffic at random so the
        // list regularly reaches both full and empty.
        run_left = 0;
        mode = 0;
        for (int n = 0; n < RANDOM_OPS; n++)
        begin
            if (run_left == 0)
            begin
                mode = $urandom_range(0, 2);
                run_left = $urandom_range(20, 80);
            end
            run_left--;
            ins_share = (mode == 0) ? 85 : (mode == 1) ? 12 : 48;
            pick = $urandom_range(0, 99);
            if (pick < 1)
                act = ACT_CLEAR;
            else if (pick < 2)
                act = ACT_UNUSED;
            else if (pick < 2 + ins_share)
                act = ACT_INSERT;
            else
                act = ACT_REMOVE;
            case ($urandom_range(0, 5))
                0, 1:
                begin
                    val = $urandom;
                end
                2, 3:
                begin
                    val = $urandom_range(0, 16);
                    val = val - 8;
                end
                4:
                begin
                    val = ($urandom_range(0, 1) != 0) ? VAL_MAX : VAL_MIN;
                end
                default:
                begin
                    val = ($urandom_range(0, 1) != 0) ? -1 : 0;
                end
            endcase
            if (gen_len > 0 && $urandom_range(0, 9) < 8)
                idx = 5'($urandom_range(0, gen_len - 1));
            else
                idx = 5'($urandom_range(0, 31));
            add_op(act, val, idx, (n % 400) == 200);
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending.size() > 0 || in_valid || expected_q.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Checked %0d results; peak fill %0d of %0d slots.", checked, peak_fill, SLOTS);
        $display("Inserts refused as full: %0d, removes of unoccupied slots: %0d.",
                 rejects, noslots);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
